// ===== rtl/xsr_pkg.sv =====
// Shared types, codes and constants of the xoshiro256** generator.
`default_nettype none

package xsr_pkg;

	localparam int WORD_W    = 64;
	localparam int CFG_AW    = 4;
	localparam int DIV_STEPS = 64;
	localparam int JUMP_BITS = 256;
	localparam int MAX_TRIES = 256;
	localparam int CNT_W     = 9;

	localparam logic [CFG_AW-1:0] SEED_ADDR = CFG_AW'(0);

	localparam logic [WORD_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] MIX_MUL2   = 64'h94d049bb133111eb;

	localparam logic [JUMP_BITS-1:0] JUMP_POLY = {
		64'h39abdc4539b888b8, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
	};

	typedef struct packed {
		logic [2:0]        op;
		logic [WORD_W-1:0] bound;
		logic [1:0]        word_index;
		logic [WORD_W-1:0] word_value;
	} req_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              status;
	} rsp_word_t;

	typedef enum logic [2:0] {
		OP_DRAW    = 3'd0,
		OP_BOUNDED = 3'd1,
		OP_JUMP    = 3'd2,
		OP_RESEED  = 3'd3,
		OP_LOAD    = 3'd4
	} op_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_STEP,
		ST_RAW,
		ST_CHECK,
		ST_THR_DIV,
		ST_THR_SAVE,
		ST_MOD_DIV,
		ST_JSTEP,
		ST_JFIN,
		ST_SADD,
		ST_MA,
		ST_MB,
		ST_MC,
		ST_MD,
		ST_X27,
		ST_WR,
		ST_RESULT
	} st_t;

	typedef enum logic [2:0] {
		SW_HOLD,
		SW_ADV,
		SW_JACC,
		SW_LOAD,
		SW_MIX
	} sw_op_t;

	typedef enum logic [1:0] {
		DIV_HOLD,
		DIV_LOAD_THR,
		DIV_LOAD_RAW,
		DIV_STEP
	} div_op_t;

	typedef enum logic [1:0] {
		JA_HOLD,
		JA_CLEAR,
		JA_STEP
	} ja_op_t;

	typedef enum logic [1:0] {
		MX_HOLD,
		MX_SEED,
		MX_ZERO,
		MX_ADD
	} mx_op_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LL,
		MUL_LH,
		MUL_HL
	} mul_op_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADDHI
	} acc_op_t;

	typedef enum logic [1:0] {
		RS_ZERO,
		RS_RAW,
		RS_REM
	} res_sel_t;

	typedef struct packed {
		logic     cap;
		sw_op_t   sw_op;
		logic [1:0] wi;
		logic     raw_load;
		div_op_t  div_op;
		logic     thr_load;
		ja_op_t   ja_op;
		logic [7:0] jbit;
		mx_op_t   mx_op;
		mul_op_t  mul_op;
		logic     mul_c2;
		acc_op_t  acc_op;
		logic     z_x27;
		logic     res_load;
		res_sel_t res_sel;
		logic     res_err;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       bound_zero;
		logic       raw_ok;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/xsr_dp.sv =====
// Datapath of the generator: state words, splitmix unit, remainder unit and jump accumulator.
`default_nettype none

module xsr_dp
	import xsr_pkg::*;
(
	input  wire logic              clk,
	input  wire req_word_t         req,
	input  wire logic [WORD_W-1:0] seed,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	output rsp_word_t              rsp
);

	logic [2:0]        op_q;
	logic [WORD_W-1:0] bound_q;
	logic [1:0]        widx_q;
	logic [WORD_W-1:0] wval_q;

	logic [WORD_W-1:0] s_q [4];
	logic [WORD_W-1:0] jacc_q [4];
	logic [WORD_W-1:0] t5_q;
	logic [WORD_W-1:0] raw_q;
	logic [WORD_W-1:0] thr_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] macc_q;
	logic [WORD_W-1:0] z_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] res_value_q;
	logic              res_status_q;

	logic [WORD_W-1:0] adv [4];
	logic [WORD_W-1:0] n3_pre;
	logic [WORD_W-1:0] s1x5;
	logic [WORD_W-1:0] mix_sum;
	logic [WORD_W-1:0] mix_out;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [WORD_W-1:0] mul_c;
	logic [WORD_W-1:0] mul_p;
	logic [WORD_W:0]   div_t;
	logic [WORD_W+1:0] div_diff;

	// One xoshiro256 state transition.
	always_comb begin
		adv[2] = s_q[2] ^ s_q[0];
		n3_pre = s_q[3] ^ s_q[1];
		adv[1] = s_q[1] ^ adv[2];
		adv[0] = s_q[0] ^ n3_pre;
		adv[2] = adv[2] ^ (s_q[1] << 17);
		adv[3] = {n3_pre[WORD_W-46:0], n3_pre[WORD_W-1:WORD_W-45]};
	end

	assign s1x5    = s_q[1] + (s_q[1] << 2);
	assign mix_sum = macc_q + MIX_GOLDEN;
	assign mix_out = acc_q ^ (acc_q >> 31);

	assign mul_c = cmd.mul_c2 ? MIX_MUL2 : MIX_MUL1;
	assign mul_a = (cmd.mul_op == MUL_HL) ? z_q[63:32] : z_q[31:0];
	assign mul_b = (cmd.mul_op == MUL_LH) ? mul_c[63:32] : mul_c[31:0];
	assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

	assign div_t    = {rem_q, dvd_q[WORD_W-1]};
	assign div_diff = {1'b0, div_t} - {2'b00, bound_q};

	assign sts.op         = op_q;
	assign sts.bound_zero = (bound_q == '0);
	assign sts.raw_ok     = (raw_q >= thr_q);

	assign rsp.value  = res_value_q;
	assign rsp.status = res_status_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q    <= req.op;
			bound_q <= req.bound;
			widx_q  <= req.word_index;
			wval_q  <= req.word_value;
		end
		if (cmd.sw_op == SW_ADV) begin
			t5_q <= {s1x5[WORD_W-8:0], s1x5[WORD_W-1:WORD_W-7]};
		end
		if (cmd.raw_load) begin
			raw_q <= t5_q + (t5_q << 3);
		end
		if (cmd.thr_load) begin
			thr_q <= rem_q;
		end
		case (cmd.div_op)
			DIV_LOAD_THR: begin
				rem_q <= '0;
				dvd_q <= WORD_W'(0) - bound_q;
			end
			DIV_LOAD_RAW: begin
				rem_q <= '0;
				dvd_q <= raw_q;
			end
			DIV_STEP: begin
				rem_q <= div_diff[WORD_W+1] ? div_t[WORD_W-1:0] : div_diff[WORD_W-1:0];
				dvd_q <= dvd_q << 1;
			end
			default: begin
			end
		endcase
		case (cmd.mx_op)
			MX_SEED: macc_q <= seed;
			MX_ZERO: macc_q <= '0;
			MX_ADD: begin
				macc_q <= mix_sum;
				z_q    <= mix_sum ^ (mix_sum >> 30);
			end
			default: begin
			end
		endcase
		if (cmd.z_x27) begin
			z_q <= acc_q ^ (acc_q >> 27);
		end
		if (cmd.mul_op != MUL_NONE) begin
			prod_q <= mul_p;
		end
		case (cmd.acc_op)
			ACC_LOAD:  acc_q <= prod_q;
			ACC_ADDHI: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
			default: begin
			end
		endcase
		for (int k = 0; k < 4; k++) begin
			case (cmd.ja_op)
				JA_CLEAR: jacc_q[k] <= '0;
				JA_STEP: begin
					if (JUMP_POLY[cmd.jbit]) begin
						jacc_q[k] <= jacc_q[k] ^ s_q[k];
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RS_RAW:  res_value_q <= raw_q;
				RS_REM:  res_value_q <= rem_q;
				default: res_value_q <= '0;
			endcase
			res_status_q <= cmd.res_err;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			case (cmd.sw_op)
				SW_ADV:  s_q[k] <= adv[k];
				SW_JACC: s_q[k] <= jacc_q[k];
				SW_LOAD: begin
					if (widx_q == 2'(k)) begin
						s_q[k] <= wval_q;
					end
				end
				SW_MIX: begin
					if (cmd.wi == 2'(k)) begin
						s_q[k] <= mix_out;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/xsr_ctrl.sv =====
// Controller state machine that sequences draws, remainders, jumps and reseeds.
`default_nettype none

module xsr_ctrl
	import xsr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	st_t              st_q;
	st_t              st_d;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       wi_q;
	logic             sec_q;
	logic             init_q;
	logic             out_valid_q;
	logic             accept;
	logic             res_go;
	logic             last_div;
	logic             last_try;

	assign req_stall = (st_q != ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign accept    = req_valid && (st_q == ST_IDLE);
	assign res_go    = !out_valid_q || !rsp_stall;
	assign last_div  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign last_try  = sts.raw_ok || (cnt_q == CNT_W'(MAX_TRIES));

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_INIT: st_d = ST_SADD;
			ST_IDLE: begin
				if (accept) begin
					st_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (op_t'(sts.op))
					OP_DRAW:    st_d = ST_STEP;
					OP_BOUNDED: st_d = sts.bound_zero ? ST_RESULT : ST_THR_DIV;
					OP_JUMP:    st_d = ST_JSTEP;
					OP_RESEED:  st_d = ST_SADD;
					default:    st_d = ST_RESULT;
				endcase
			end
			ST_STEP: st_d = ST_RAW;
			ST_RAW: st_d = (op_t'(sts.op) == OP_DRAW) ? ST_RESULT : ST_CHECK;
			ST_CHECK: st_d = last_try ? ST_MOD_DIV : ST_STEP;
			ST_THR_DIV: begin
				if (last_div) begin
					st_d = ST_THR_SAVE;
				end
			end
			ST_THR_SAVE: st_d = ST_STEP;
			ST_MOD_DIV: begin
				if (last_div) begin
					st_d = ST_RESULT;
				end
			end
			ST_JSTEP: begin
				if (cnt_q == CNT_W'(JUMP_BITS - 1)) begin
					st_d = ST_JFIN;
				end
			end
			ST_JFIN: st_d = ST_RESULT;
			ST_SADD: st_d = ST_MA;
			ST_MA: st_d = ST_MB;
			ST_MB: st_d = ST_MC;
			ST_MC: st_d = ST_MD;
			ST_MD: st_d = sec_q ? ST_WR : ST_X27;
			ST_X27: st_d = ST_MA;
			ST_WR: begin
				if (wi_q != 2'd3) begin
					st_d = ST_SADD;
				end else if (init_q) begin
					st_d = ST_IDLE;
				end else begin
					st_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (res_go) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.sw_op    = SW_HOLD;
		cmd.div_op   = DIV_HOLD;
		cmd.ja_op    = JA_HOLD;
		cmd.mx_op    = MX_HOLD;
		cmd.mul_op   = MUL_NONE;
		cmd.acc_op   = ACC_HOLD;
		cmd.res_sel  = RS_ZERO;
		cmd.wi       = wi_q;
		cmd.jbit     = cnt_q[7:0];
		cmd.mul_c2   = sec_q;
		case (st_q)
			ST_INIT: cmd.mx_op = MX_ZERO;
			ST_IDLE: cmd.cap = accept;
			ST_DECODE: begin
				case (op_t'(sts.op))
					OP_BOUNDED: cmd.div_op = DIV_LOAD_THR;
					OP_JUMP:    cmd.ja_op = JA_CLEAR;
					OP_RESEED:  cmd.mx_op = MX_SEED;
					OP_LOAD:    cmd.sw_op = SW_LOAD;
					default: begin
					end
				endcase
			end
			ST_STEP: cmd.sw_op = SW_ADV;
			ST_RAW: cmd.raw_load = 1'b1;
			ST_CHECK: begin
				if (last_try) begin
					cmd.div_op = DIV_LOAD_RAW;
				end
			end
			ST_THR_DIV: cmd.div_op = DIV_STEP;
			ST_THR_SAVE: cmd.thr_load = 1'b1;
			ST_MOD_DIV: cmd.div_op = DIV_STEP;
			ST_JSTEP: begin
				cmd.ja_op = JA_STEP;
				cmd.sw_op = SW_ADV;
			end
			ST_JFIN: cmd.sw_op = SW_JACC;
			ST_SADD: cmd.mx_op = MX_ADD;
			ST_MA: cmd.mul_op = MUL_LL;
			ST_MB: begin
				cmd.acc_op = ACC_LOAD;
				cmd.mul_op = MUL_LH;
			end
			ST_MC: begin
				cmd.acc_op = ACC_ADDHI;
				cmd.mul_op = MUL_HL;
			end
			ST_MD: cmd.acc_op = ACC_ADDHI;
			ST_X27: cmd.z_x27 = 1'b1;
			ST_WR: cmd.sw_op = SW_MIX;
			ST_RESULT: begin
				cmd.res_load = res_go;
				case (op_t'(sts.op))
					OP_DRAW: cmd.res_sel = RS_RAW;
					OP_BOUNDED: begin
						if (sts.bound_zero) begin
							cmd.res_err = 1'b1;
						end else begin
							cmd.res_sel = RS_REM;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_INIT;
			cnt_q       <= '0;
			wi_q        <= '0;
			sec_q       <= 1'b0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_INIT: begin
					wi_q  <= '0;
					sec_q <= 1'b0;
				end
				ST_DECODE: begin
					cnt_q <= '0;
					wi_q  <= '0;
					sec_q <= 1'b0;
				end
				ST_STEP, ST_THR_DIV, ST_MOD_DIV, ST_JSTEP: cnt_q <= cnt_q + 1'b1;
				ST_THR_SAVE: cnt_q <= '0;
				ST_CHECK: begin
					if (last_try) begin
						cnt_q <= '0;
					end
				end
				ST_X27: sec_q <= 1'b1;
				ST_WR: begin
					sec_q <= 1'b0;
					wi_q  <= wi_q + 1'b1;
					if (wi_q == 2'd3) begin
						init_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (st_q == ST_RESULT && res_go) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/xoshiro256_random_generator.sv =====
// Top level of the xoshiro256** generator with its seed register port.
// A bounded draw runs two 64-step remainder passes, one for the threshold and one for the result.
// One word is in work at a time; the next is taken the cycle after its result is registered.
// After reset a splitmix pass expands seed zero into the state before the first word.
// The seed register resets to zero; the output register holds one result until taken.
`default_nettype none

module xoshiro256_random_generator
	import xsr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_word_t         req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_word_t              rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [WORD_W-1:0] pwdata,
	output logic [WORD_W-1:0]      prdata,
	output logic                   pready
);

	logic [WORD_W-1:0] seed_q;
	dp_cmd_t           cmd;
	dp_sts_t           sts;

	assign pready = 1'b1;
	assign prdata = (paddr == SEED_ADDR) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (psel && penable && pwrite && paddr == SEED_ADDR) begin
			seed_q <= pwdata;
		end
	end

	xsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	xsr_dp u_dp (
		.clk    (clk),
		.req    (req),
		.seed   (seed_q),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the xoshiro256** generator with its seed register port.
`timescale 1ns / 100ps

module tb;
	import xsr_pkg::*;

	localparam int STUCK_LIMIT = 20000;
	localparam int TRY_LIMIT   = 256;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE      = 60;

	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MUL_B  = 64'h94d049bb133111eb;
	localparam logic [63:0] LEAP [4] = '{
		64'h180ec6d33cfd0aba, 64'hd5a61266f0c9392c,
		64'ha9582618e03fc9aa, 64'h39abdc4539b888b8
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_word_t         req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_word_t         rsp;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [WORD_W-1:0] pwdata = '0;
	logic [WORD_W-1:0] prdata;
	logic              pready;

	xoshiro256_random_generator u_top (
		.clk, .arst_n, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	req_word_t   pending_reqs [$];
	rsp_word_t   want_rsp [$];
	logic [63:0] gen_state [4];
	logic [63:0] seed_model;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_kick = 1'b0;
	int          hold_left = 0;
	int          stuck_cycles = 0;
	int          err_count = 0;
	int          results_checked = 0;
	int          words_sent = 0;
	int          op_count [8] = '{default: 0};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
		return (x << k) | (x >> (64 - k));
	endfunction

	function automatic void expand_seed(input logic [63:0] s);
		logic [63:0] acc;
		logic [63:0] z;
		int i;
		acc = s;
		for (i = 0; i < 4; i++) begin
			acc = acc + GOLDEN;
			z = acc;
			z = (z ^ (z >> 30)) * MUL_A;
			z = (z ^ (z >> 27)) * MUL_B;
			gen_state[i] = z ^ (z >> 31);
		end
	endfunction

	function automatic logic [63:0] gen_next();
		logic [63:0] out;
		logic [63:0] t;
		out = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
		t = gen_state[1] << 17;
		gen_state[2] = gen_state[2] ^ gen_state[0];
		gen_state[3] = gen_state[3] ^ gen_state[1];
		gen_state[1] = gen_state[1] ^ gen_state[2];
		gen_state[0] = gen_state[0] ^ gen_state[3];
		gen_state[2] = gen_state[2] ^ t;
		gen_state[3] = rotl64(gen_state[3], 45);
		return out;
	endfunction

	function automatic void leap_state();
		logic [63:0] acc [4];
		logic [63:0] unused;
		int i;
		int b;
		int k;
		acc = '{default: 64'd0};
		for (i = 0; i < 4; i++) begin
			for (b = 0; b < 64; b++) begin
				if (LEAP[i][b]) begin
					for (k = 0; k < 4; k++) acc[k] = acc[k] ^ gen_state[k];
				end
				unused = gen_next();
			end
		end
		for (k = 0; k < 4; k++) gen_state[k] = acc[k];
	endfunction

	function automatic rsp_word_t predict_rsp(input req_word_t w);
		rsp_word_t   r;
		logic [63:0] thr;
		logic [63:0] v;
		int          tries;
		r = '0;
		case (w.op)
			OP_DRAW: begin
				r.value = gen_next();
			end
			OP_BOUNDED: begin
				if (w.bound == 64'd0) begin
					r.status = 1'b1;
				end else begin
					thr = (64'd0 - w.bound) % w.bound;
					v = 64'd0;
					for (tries = 0; tries < TRY_LIMIT; tries++) begin
						v = gen_next();
						if (v >= thr) break;
					end
					r.value = v % w.bound;
				end
			end
			OP_JUMP: begin
				leap_state();
			end
			OP_RESEED: begin
				expand_seed(seed_model);
			end
			OP_LOAD: begin
				gen_state[w.word_index] = w.word_value;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_bound();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 64'd0;
		if (r < 4) return 64'($urandom_range(1, 16));
		if (r < 7) return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 8));
		if (r < 12) return rand64() >> $urandom_range(0, 63);
		return rand64();
	endfunction

	function automatic logic [2:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return OP_DRAW;
		if (r < 78) return OP_BOUNDED;
		if (r < 83) return OP_JUMP;
		if (r < 88) return OP_RESEED;
		if (r < 96) return OP_LOAD;
		return 3'($urandom_range(int'(OP_LOAD) + 1, 7));
	endfunction

	function automatic req_word_t build_req(input logic [2:0] op, input logic [63:0] bound,
			input logic [1:0] idx, input logic [63:0] val);
		req_word_t w;
		w.op = op;
		w.bound = bound;
		w.word_index = idx;
		w.word_value = val;
		return w;
	endfunction

	function automatic req_word_t rand_req(input logic [2:0] op);
		return build_req(op, rand_bound(), 2'($urandom_range(0, 3)), rand64());
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
		err_count++;
	endtask

	task automatic write_seed(input logic [63:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SEED_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		seed_model = v;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || req_valid || want_rsp.size() != 0) @(negedge clk);
	endtask

	task automatic run_phase(input logic [63:0] seed, input int sidle, input int rstall,
			input int nwords, input bit squeeze);
		int i;
		write_seed(seed);
		send_idle_pct <= sidle;
		recv_stall_pct <= rstall;
		if (squeeze) begin
			hold_kick <= 1'b1;
			@(posedge clk);
			hold_kick <= 1'b0;
		end
		@(negedge clk);
		for (i = 0; i < nwords; i++) pending_reqs.push_back(rand_req(pick_op()));
		drain();
	endtask

	// Request driver: a word stays on the bus until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				want_rsp.push_back(predict_rsp(req));
				op_count[req.op]++;
				words_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_kick) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: every taken word is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t due;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (want_rsp.size() == 0) begin
					report_mismatch("unexpected result", rsp.value, 64'd0);
				end else begin
					due = want_rsp.pop_front();
					if (rsp.value !== due.value) begin
						report_mismatch("value", rsp.value, due.value);
					end
					if (rsp.status !== due.status) begin
						report_mismatch("status", 64'(rsp.status), 64'(due.status));
					end
					results_checked++;
				end
			end
			rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		int u;
		seed_model = 64'd0;
		expand_seed(64'd0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Edge cases first, with the bus running at full speed.
		write_seed(64'd0);
		@(negedge clk);
		pending_reqs.push_back(build_req(OP_DRAW, '1, 2'd3, '1));
		pending_reqs.push_back(build_req(OP_BOUNDED, 64'd0, 2'd0, 64'd0));
		pending_reqs.push_back(build_req(OP_BOUNDED, 64'd1, 2'd1, rand64()));
		pending_reqs.push_back(build_req(OP_BOUNDED, '1, 2'd2, rand64()));
		pending_reqs.push_back(build_req(OP_BOUNDED, 64'h8000_0000_0000_0001, 2'd3, '1));
		pending_reqs.push_back(build_req(OP_BOUNDED, 64'h8000_0000_0000_0000, 2'd0, 64'd0));
		pending_reqs.push_back(build_req(OP_JUMP, rand64(), 2'd1, rand64()));
		pending_reqs.push_back(build_req(OP_RESEED, rand64(), 2'd2, rand64()));
		pending_reqs.push_back(build_req(OP_DRAW, 64'd0, 2'd0, 64'd0));
		pending_reqs.push_back(build_req(OP_LOAD, 64'd0, 2'd0, '1));
		pending_reqs.push_back(build_req(OP_LOAD, '1, 2'd1, 64'h0123_4567_89ab_cdef));
		pending_reqs.push_back(build_req(OP_LOAD, rand64(), 2'd2, rand64()));
		pending_reqs.push_back(build_req(OP_LOAD, rand64(), 2'd3, rand64()));
		pending_reqs.push_back(build_req(OP_DRAW, rand64(), 2'd1, rand64()));
		for (u = int'(OP_LOAD) + 1; u < 8; u++) pending_reqs.push_back(rand_req(3'(u)));
		// An all-zero state never leaves zero, and a bounded draw rejects every try.
		for (u = 0; u < 4; u++) pending_reqs.push_back(build_req(OP_LOAD, '1, 2'(u), 64'd0));
		pending_reqs.push_back(build_req(OP_DRAW, '1, 2'd0, '1));
		pending_reqs.push_back(build_req(OP_BOUNDED, 64'd3, 2'd0, '1));
		pending_reqs.push_back(build_req(OP_JUMP, 64'd0, 2'd0, 64'd0));
		pending_reqs.push_back(build_req(OP_RESEED, 64'd0, 2'd0, 64'd0));
		drain();

		run_phase('1, 0, 0, 250, 1'b0);
		run_phase(rand64(), 88, 0, 200, 1'b0);
		run_phase(rand64(), 0, 88, 200, 1'b0);
		run_phase(64'd1, 27, 27, 200, 1'b0);
		run_phase(rand64(), 0, 0, 80, 1'b1);

		repeat (SETTLE) @(posedge clk);
		if (want_rsp.size() != 0) begin
			report_mismatch("results never delivered", 64'(want_rsp.size()), 64'd0);
		end
		$display("Sent %0d words: %0d draws, %0d bounded, %0d jumps, %0d reseeds,",
			words_sent, op_count[OP_DRAW], op_count[OP_BOUNDED], op_count[OP_JUMP],
			op_count[OP_RESEED]);
		$display("%0d loads, %0d unused codes; %0d results checked. %s",
			op_count[OP_LOAD], op_count[5] + op_count[6] + op_count[7], results_checked,
			"Seeds included zero and all ones, with gaps, stalls and a long hold-off.");
		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
